[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/pat2d_pkg.sv]
// Package for the 2D point affine transform: register map, mode codes,
// field widths and the Q1.14 sine table built at elaboration.
// No dependencies.
package pat2d_pkg;

   // coordinate width default (signed Q12.4 at 16 bits)
   localparam int COORD_WIDTH_DEFAULT = 16;

   // configuration port: six 32-bit registers at byte address 4*i
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam int MODE_W  = 3;
   localparam int ANGLE_W = 9;
   localparam int SCALE_W = 16;
   localparam int SIN_W   = 15;  // table magnitude, up to 16384
   localparam int TRIG_W  = 16;  // signed Q1.14 sine / cosine
   localparam int SIN_IDX_W = 7;

   localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_ANGLE    = 3'd1,
      CSR_OFFSET_X = 3'd2,
      CSR_OFFSET_Y = 3'd3,
      CSR_SCALE_X  = 3'd4,
      CSR_SCALE_Y  = 3'd5
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_TRANSLATE = 3'd0,
      MODE_SCALE     = 3'd1,
      MODE_ROTATE    = 3'd2,
      MODE_REFLECT_X = 3'd3,
      MODE_REFLECT_Y = 3'd4,
      MODE_SWAP      = 3'd5
   } mode_type;

   // angle quadrant boundaries in degrees
   localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
   localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
   localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
   localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

   // sine table, 0..90 degrees
   localparam int SIN_ENTRIES = 91;
   typedef logic [SIN_W-1:0] sin_tab_type [SIN_ENTRIES];

   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] SIN_ONE  = 64'd16384;
   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // Q30 Taylor series with truncating steps, rounded to Q1.14
   function automatic sin_tab_type build_sin_table();
      sin_tab_type       tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic [63:0]       rnd;
      logic signed [63:0] acc;
      for (int k = 0; k < SIN_ENTRIES; k++) begin
         x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
         x2   = (x * x) >> 30;
         term = x;
         acc  = signed'(x);
         for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 0) begin
               acc = acc - signed'(term);
            end else begin
               acc = acc + signed'(term);
            end
         end
         if (acc < 0) begin
            acc = '0;
         end
         rnd = (unsigned'(acc) + 64'd32768) >> 16;
         tab[k] = (rnd > SIN_ONE) ? SIN_ONE[SIN_W-1:0] : rnd[SIN_W-1:0];
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TABLE = build_sin_table();

endpackage

[rtl/point_affine_transform_2d_top.sv]
// Top level of the 2D point affine transform: stream in, stream out, APB registers.
// Depends on pat2d_pkg.
//
// One vertex is accepted per clock while the output does not stall. It is captured
// in an input register, one combinational pass does the translate, scale, rotate,
// reflect or swap with rounding and saturation, and the result register takes the
// outcome of that pass. The sustained rate is one vertex per cycle without output
// stalls, set by that single registered pass (its deepest path
// is the rotate multiply-add). A stalled output holds the result while the input
// register still takes one more vertex. Sine and cosine are looked up from the
// angle register into their own registers, so a new angle applies to vertices
// accepted from the cycle after the write. No clearing pass after reset.
module point_affine_transform_2d_top #(
   parameter int COORD_WIDTH = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int DATA_W      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // input vertex stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_W-1:0]                 req_tdata,   // px, py
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [DATA_W-1:0]                 rsp_tdata,   // qx, qy
   output logic [0:0]                        rsp_tuser,   // saturated
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pat2d_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pat2d_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pat2d_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import pat2d_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int EXT_W = CW + 9;
   localparam logic signed [EXT_W-1:0] SAT_HI = {{(EXT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

   // configuration registers
   logic [MODE_W-1:0]         mode_ff;
   logic [ANGLE_W-1:0]        angle_ff;
   logic signed [CW-1:0]      ofs_x_ff;
   logic signed [CW-1:0]      ofs_y_ff;
   logic signed [SCALE_W-1:0] scl_x_ff;
   logic signed [SCALE_W-1:0] scl_y_ff;

   logic                  csr_wr;
   logic [CSR_IDX_W-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TRANSLATE;
         angle_ff <= '0;
         ofs_x_ff <= '0;
         ofs_y_ff <= '0;
         scl_x_ff <= SCALE_RESET;
         scl_y_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MODE:     mode_ff  <= csr_pwdata[MODE_W-1:0];
            CSR_ANGLE:    angle_ff <= csr_pwdata[ANGLE_W-1:0];
            CSR_OFFSET_X: ofs_x_ff <= csr_pwdata[CW-1:0];
            CSR_OFFSET_Y: ofs_y_ff <= csr_pwdata[CW-1:0];
            CSR_SCALE_X:  scl_x_ff <= csr_pwdata[SCALE_W-1:0];
            CSR_SCALE_Y:  scl_y_ff <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         CSR_MODE:     csr_prdata = CSR_DATA_W'(mode_ff);
         CSR_ANGLE:    csr_prdata = CSR_DATA_W'(angle_ff);
         CSR_OFFSET_X: csr_prdata = CSR_DATA_W'(unsigned'(ofs_x_ff));
         CSR_OFFSET_Y: csr_prdata = CSR_DATA_W'(unsigned'(ofs_y_ff));
         CSR_SCALE_X:  csr_prdata = CSR_DATA_W'(unsigned'(scl_x_ff));
         CSR_SCALE_Y:  csr_prdata = CSR_DATA_W'(unsigned'(scl_y_ff));
         default:      csr_prdata = '0;
      endcase
   end

   // sine / cosine from the angle, folded into the first quadrant
   logic [ANGLE_W-1:0]       ang_red;
   logic [ANGLE_W-1:0]       s_idx;
   logic [ANGLE_W-1:0]       c_idx;
   logic                     s_neg;
   logic                     c_neg;
   logic [SIN_W-1:0]         s_mag;
   logic [SIN_W-1:0]         c_mag;
   logic signed [TRIG_W-1:0] sin_in;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   always_comb begin
      ang_red = (angle_ff >= DEG_360) ? angle_ff - DEG_360 : angle_ff;
      if (ang_red <= DEG_90) begin
         s_idx = ang_red;            s_neg = 1'b0;
         c_idx = DEG_90 - ang_red;   c_neg = 1'b0;
      end else if (ang_red <= DEG_180) begin
         s_idx = DEG_180 - ang_red;  s_neg = 1'b0;
         c_idx = ang_red - DEG_90;   c_neg = 1'b1;
      end else if (ang_red <= DEG_270) begin
         s_idx = ang_red - DEG_180;  s_neg = 1'b1;
         c_idx = DEG_270 - ang_red;  c_neg = 1'b1;
      end else begin
         s_idx = DEG_360 - ang_red;  s_neg = 1'b1;
         c_idx = ang_red - DEG_270;  c_neg = 1'b0;
      end
      s_mag  = SIN_TABLE[s_idx[SIN_IDX_W-1:0]];
      c_mag  = SIN_TABLE[c_idx[SIN_IDX_W-1:0]];
      sin_in = s_neg ? -signed'({1'b0, s_mag}) : signed'({1'b0, s_mag});
      cos_in = c_neg ? -signed'({1'b0, c_mag}) : signed'({1'b0, c_mag});
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   // input register and result register with backpressure
   logic                 in_vld_ff;
   logic signed [CW-1:0] in_x_ff;
   logic signed [CW-1:0] in_y_ff;
   logic                 out_vld_ff;
   logic [CW-1:0]        qx_ff;
   logic [CW-1:0]        qy_ff;
   logic                 sat_ff;
   logic                 out_adv;

   assign out_adv    = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_x_ff <= req_tdata[CW-1:0];
         in_y_ff <= req_tdata[2*CW-1:CW];
      end
   end

   // transform datapath
   logic signed [CW:0]         dx;
   logic signed [CW:0]         dy;
   logic signed [CW+16:0]      p_xc;
   logic signed [CW+16:0]      p_ys;
   logic signed [CW+16:0]      p_xs;
   logic signed [CW+16:0]      p_yc;
   logic signed [CW+17:0]      rot_sx;
   logic signed [CW+17:0]      rot_sy;
   logic [CW+17:0]             rot_bx;
   logic [CW+17:0]             rot_by;
   logic signed [CW+3:0]       rot_qx;
   logic signed [CW+3:0]       rot_qy;
   logic signed [CW+15:0]      scl_px;
   logic signed [CW+15:0]      scl_py;
   logic [CW+15:0]             scl_bx;
   logic [CW+15:0]             scl_by;
   logic signed [CW+7:0]       scl_qx;
   logic signed [CW+7:0]       scl_qy;
   logic signed [EXT_W-1:0]    rx;
   logic signed [EXT_W-1:0]    ry;
   logic [CW-1:0]              qx_in;
   logic [CW-1:0]              qy_in;
   logic                       sat_in;

   always_comb begin
      // rotation about the pivot, products in Q.18
      dx     = {in_x_ff[CW-1], in_x_ff} - {ofs_x_ff[CW-1], ofs_x_ff};
      dy     = {in_y_ff[CW-1], in_y_ff} - {ofs_y_ff[CW-1], ofs_y_ff};
      p_xc   = dx * cos_ff;
      p_ys   = dy * sin_ff;
      p_xs   = dx * sin_ff;
      p_yc   = dy * cos_ff;
      rot_sx = {p_xc[CW+16], p_xc} - {p_ys[CW+16], p_ys};
      rot_sy = {p_xs[CW+16], p_xs} + {p_yc[CW+16], p_yc};
      rot_bx = rot_sx + {{(CW+4){1'b0}}, 14'h2000};
      rot_by = rot_sy + {{(CW+4){1'b0}}, 14'h2000};
      rot_qx = rot_bx[CW+17:14];
      rot_qy = rot_by[CW+17:14];

      // scaling, products in Q.12
      scl_px = in_x_ff * scl_x_ff;
      scl_py = in_y_ff * scl_y_ff;
      scl_bx = scl_px + {{(CW+8){1'b0}}, 8'h80};
      scl_by = scl_py + {{(CW+8){1'b0}}, 8'h80};
      scl_qx = scl_bx[CW+15:8];
      scl_qy = scl_by[CW+15:8];

      case (mode_ff)
         MODE_TRANSLATE: begin
            rx = EXT_W'(in_x_ff) + EXT_W'(ofs_x_ff);
            ry = EXT_W'(in_y_ff) + EXT_W'(ofs_y_ff);
         end
         MODE_SCALE: begin
            rx = EXT_W'(scl_qx);
            ry = EXT_W'(scl_qy);
         end
         MODE_ROTATE: begin
            rx = EXT_W'(rot_qx) + EXT_W'(ofs_x_ff);
            ry = EXT_W'(rot_qy) + EXT_W'(ofs_y_ff);
         end
         MODE_REFLECT_X: begin
            rx = EXT_W'(in_x_ff);
            ry = -EXT_W'(in_y_ff);
         end
         MODE_REFLECT_Y: begin
            rx = -EXT_W'(in_x_ff);
            ry = EXT_W'(in_y_ff);
         end
         MODE_SWAP: begin
            rx = EXT_W'(in_y_ff);
            ry = EXT_W'(in_x_ff);
         end
         default: begin
            rx = EXT_W'(in_x_ff);
            ry = EXT_W'(in_y_ff);
         end
      endcase

      // saturate each coordinate and flag any clamp
      sat_in = 1'b0;
      if (rx > SAT_HI) begin
         qx_in = SAT_HI[CW-1:0];  sat_in = 1'b1;
      end else if (rx < SAT_LO) begin
         qx_in = SAT_LO[CW-1:0];  sat_in = 1'b1;
      end else begin
         qx_in = rx[CW-1:0];
      end
      if (ry > SAT_HI) begin
         qy_in = SAT_HI[CW-1:0];  sat_in = 1'b1;
      end else if (ry < SAT_LO) begin
         qy_in = SAT_LO[CW-1:0];  sat_in = 1'b1;
      end else begin
         qy_in = ry[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_adv) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && in_vld_ff) begin
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = DATA_W'({qy_ff, qx_ff});
   assign rsp_tuser  = sat_ff;

endmodule

[rtl/pat2d_checker.sv]
// Port-level checks for the 2D point affine transform, bound to the top level.
// Depends on pat2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pat2d_checker #(
   parameter int COORD_WIDTH = pat2d_pkg::COORD_WIDTH_DEFAULT,
   parameter int DATA_W      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,   // qx, qy
   input logic [0:0]        rsp_tuser    // saturated
);
   import pat2d_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};

   logic [CW-1:0] qx;
   logic [CW-1:0] qy;
   logic          in_xfer;
   logic          rsp_stall;
   logic [DATA_W:0] rsp_word;
   logic          q_at_limit;

   assign qx         = rsp_tdata[CW-1:0];
   assign qy         = rsp_tdata[2*CW-1:CW];
   assign in_xfer    = req_tvalid & req_tready;
   assign rsp_stall  = rsp_tvalid & ~rsp_tready;
   assign rsp_word   = {rsp_tuser, rsp_tdata};
   assign q_at_limit = (qx == Q_MAX) || (qx == Q_MIN) || (qy == Q_MAX) || (qy == Q_MIN);

   // no result is offered right after reset
   `AST_NEXT_ALWAYS(a_rsp_idle_after_reset, clock, reset, !rsp_tvalid)

   // a stalled result holds its data and flag
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // a clamp flag always comes with a coordinate at a range limit
   `AST_IMPL(a_sat_at_limit, clock, reset, rsp_tvalid && rsp_tuser[0], q_at_limit)

   // with the result register empty the input side never stalls
   `AST_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // a vertex taken while rsp_tready is high is followed by a result
   `AST_NEXT(a_xfer_reaches_out, clock, reset, in_xfer && rsp_tready, ##1 rsp_tvalid)

endmodule

bind point_affine_transform_2d_top pat2d_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .DATA_W      (DATA_W)
) u_pat2d_checker (.*);

[tb/sv/tb_point_affine_transform_2d_top.sv]
// Self-checking testbench for point_affine_transform_2d_top: a directed vector list,
// then random phases under fresh register settings, checked against a local transform model.
// Depends on pat2d_pkg and the point_affine_transform_2d_top RTL.
module tb_point_affine_transform_2d_top;
   import pat2d_pkg::*;

   typedef longint unsigned u64_type;

   localparam u64_type PI_SCALED = 64'd3373259426;  // round(pi * 2^30)
   localparam int   STALL_LIMIT = 1000;
   localparam int   NUM_DIRECTED = 22;
   localparam int   NUM_PHASES   = 12;
   localparam int   PHASE_POINTS = 59;
   localparam int   TAIL_POINTS  = 100;

   // mode codes with no transform behind them, and register slots past the map
   localparam logic [MODE_W-1:0]    MODE_RSVD_6 = 3'd6;
   localparam logic [MODE_W-1:0]    MODE_RSVD_7 = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ANGLE_W-1:0] angle;
      logic [15:0]        ox;
      logic [15:0]        oy;
      logic [15:0]        sx;
      logic [15:0]        sy;
   } xform_cfg_type;

   typedef struct packed {
      logic [15:0] qx;
      logic [15:0] qy;
      logic        sat;
   } point_result_type;

   typedef struct packed {
      logic             fixed;  // expectation typed in the vector list
      point_result_type want;
   } point_note_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ANGLE_W-1:0] angle;
      logic [15:0]        ox;
      logic [15:0]        oy;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic               poke;   // also hit the unmapped register slots
      logic [15:0]        px;
      logic [15:0]        py;
      logic               fixed;
      logic [15:0]        qx;
      logic [15:0]        qy;
      logic               sat;
   } vector_row_type;

   // mode, angle, ox, oy, sx, sy, poke, px, py, fixed, qx, qy, sat
   localparam vector_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // reset values: translate by zero; then offsets that clamp
      '{MODE_TRANSLATE, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 1'b0},
      '{MODE_TRANSLATE, 9'd0, 16'h0001, 16'hFFFF, 16'h0100, 16'h0100, 1'b0,
        16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 1'b1},
      '{MODE_TRANSLATE, 9'd0, 16'h8000, 16'h7FFF, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF, 1'b1},
      // scale: unity, extremes, negate and zero, half with ties upward
      '{MODE_SCALE, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h1234, 16'hFEDC, 1'b1, 16'h1234, 16'hFEDC, 1'b0},
      '{MODE_SCALE, 9'd0, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0,
        16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000, 1'b1},
      '{MODE_SCALE, 9'd0, 16'h0000, 16'h0000, 16'hFF00, 16'h0000, 1'b0,
        16'h8000, 16'h1234, 1'b1, 16'h7FFF, 16'h0000, 1'b1},
      '{MODE_SCALE, 9'd0, 16'h0000, 16'h0000, 16'h0080, 16'h0080, 1'b0,
        16'h0001, 16'hFFFF, 1'b1, 16'h0001, 16'h0000, 1'b0},
      // rotate: quadrant edges, wrap above 359, extreme pivots, 30 degrees
      '{MODE_ROTATE, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd90, 16'h0100, 16'hFF00, 16'h0100, 16'h0100, 1'b0,
        16'h0200, 16'h0300, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd180, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h1234, 16'hF00D, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd270, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd45, 16'h8000, 16'h8000, 16'h0100, 16'h0100, 1'b0,
        16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd359, 16'h7FFF, 16'h8000, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd360, 16'h0040, 16'h0040, 16'h0100, 16'h0100, 1'b0,
        16'h0123, 16'h0456, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd511, 16'hFFC0, 16'h0020, 16'h0100, 16'h0100, 1'b0,
        16'h0321, 16'hFABC, 1'b0, 16'h0000, 16'h0000, 1'b0},
      '{MODE_ROTATE, 9'd30, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h0010, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // reflections and swap; negating the most negative value clamps
      '{MODE_REFLECT_X, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h7FFF, 1'b1},
      '{MODE_REFLECT_X, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h1234, 16'h0010, 1'b1, 16'h1234, 16'hFFF0, 1'b0},
      '{MODE_REFLECT_Y, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1},
      '{MODE_SWAP, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000, 1'b0},
      // undefined modes pass the vertex; writes past the map change nothing
      '{MODE_RSVD_6, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
        16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF, 1'b0},
      '{MODE_RSVD_7, 9'd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b1,
        16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 1'b0}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;   // px [15:0], py [31:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;          // qx [15:0], qy [31:16]
   logic [0:0]            rsp_tuser;          // saturated [0]
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   xform_cfg_type    xf = '{MODE_TRANSLATE, 9'd0, 16'h0000, 16'h0000, 16'h0100, 16'h0100};
   point_result_type expected_xforms [$];
   point_note_type   presented_notes [$];
   int               mismatches  = 0;
   int               idle_cycles = 0;
   int               stall_left  = 0;
   int               req_gap_pct = 20;
   int               rsp_stall_pct = 20;
   logic             full_rate   = 1'b0;

   point_affine_transform_2d_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Q1.14 sine of 0..90 degrees: Q30 Taylor series, truncating steps
   function automatic longint table_sine(int unsigned deg);
      u64_type ang;
      u64_type ang_sq;
      u64_type term;
      longint  acc;
      ang    = (u64_type'(deg) * PI_SCALED + 64'd90) / 64'd180;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * ang_sq) >> 30) / u64_type'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 32768) >>> 16;
      return (acc > 16384) ? 64'sd16384 : acc;
   endfunction

   // round to nearest, ties toward plus infinity, dropping n fraction bits
   function automatic longint round_off(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'h7FFF;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // expected result of one vertex under the current register settings
   function automatic point_result_type transform_point(logic [15:0] px, logic [15:0] py);
      point_result_type r;
      longint           x, y, ox, oy, rx, ry, dx, dy, s, c;
      int unsigned      a;
      x  = longint'($signed(px));
      y  = longint'($signed(py));
      ox = longint'($signed(xf.ox));
      oy = longint'($signed(xf.oy));
      rx = x;
      ry = y;
      case (xf.mode)
         MODE_TRANSLATE: begin
            rx = x + ox;
            ry = y + oy;
         end
         MODE_SCALE: begin
            rx = round_off(x * longint'($signed(xf.sx)), 8);
            ry = round_off(y * longint'($signed(xf.sy)), 8);
         end
         MODE_ROTATE: begin
            a = xf.angle;
            if (a >= DEG_360) begin
               a = a - DEG_360;
            end
            if (a <= DEG_90) begin
               s = table_sine(a);
               c = table_sine(DEG_90 - a);
            end else if (a <= DEG_180) begin
               s = table_sine(DEG_180 - a);
               c = -table_sine(a - DEG_90);
            end else if (a <= DEG_270) begin
               s = -table_sine(a - DEG_180);
               c = -table_sine(DEG_270 - a);
            end else begin
               s = -table_sine(DEG_360 - a);
               c = table_sine(a - DEG_270);
            end
            dx = x - ox;
            dy = y - oy;
            rx = round_off(dx * c - dy * s, 14) + ox;
            ry = round_off(dx * s + dy * c, 14) + oy;
         end
         MODE_REFLECT_X: ry = -y;
         MODE_REFLECT_Y: rx = -x;
         MODE_SWAP: begin
            rx = y;
            ry = x;
         end
         default: ;
      endcase
      r.qx  = clamp16(rx);
      r.qy  = clamp16(ry);
      r.sat = (rx > 32767) || (rx < -32768) || (ry > 32767) || (ry < -32768);
      return r;
   endfunction

   // full-range values half the time, with extremes and near-zero values mixed in
   function automatic logic [15:0] pick_word();
      logic [15:0] v;
      v = 16'($urandom_range(0, 1023));
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return v - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(0, 27))
         0: return 9'd0;
         1: return 9'd90;
         2: return 9'd180;
         3: return 9'd270;
         4: return 9'd359;
         5: return 9'd360;
         6: return 9'd511;
         default: return ANGLE_W'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(0, 14);
      if (r < 12) begin
         return MODE_W'(r % 6);
      end else if (r < 14) begin
         return MODE_ROTATE;
      end
      return $urandom_range(0, 1) ? MODE_RSVD_7 : MODE_RSVD_6;
   endfunction

   task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // stop the vertex stream and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_xforms.size() != 0) @(negedge clock);
   endtask

   // reprogram all six registers, and poke the spare slots on request, while the block is idle
   task automatic apply_xform(xform_cfg_type cfg, logic junk, logic poke);
      logic [31:0] fill;
      drain();
      fill = junk ? $urandom : 32'h0;
      csr_write(CSR_MODE,     {fill[31:3], cfg.mode});
      csr_write(CSR_ANGLE,    {fill[31:9], cfg.angle});
      csr_write(CSR_OFFSET_X, {fill[31:16], cfg.ox});
      csr_write(CSR_OFFSET_Y, {fill[31:16], cfg.oy});
      csr_write(CSR_SCALE_X,  {fill[31:16], cfg.sx});
      csr_write(CSR_SCALE_Y,  {fill[31:16], cfg.sy});
      if (poke) begin
         csr_write(CSR_SPARE_6, $urandom);
         csr_write(CSR_SPARE_7, $urandom);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      xf = cfg;
   endtask

   // one vertex transfer, after an optional burst of idle cycles
   task automatic send_point(logic [15:0] px, logic [15:0] py, point_note_type note);
      int gap;
      gap = 0;
      if (!full_rate && $urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 14);
      end
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      presented_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   // result-side back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!full_rate && $urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // score results in order, then queue the expectation for each new vertex
   always @(posedge clock) begin
      point_result_type want;
      point_result_type got;
      point_note_type   note;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[0]};
            if (expected_xforms.size() == 0) begin
               note_mismatch("unexpected result, qx", 16'h0, got.qx);
            end else begin
               want = expected_xforms.pop_front();
               if (got.qx !== want.qx) note_mismatch("qx", want.qx, got.qx);
               if (got.qy !== want.qy) note_mismatch("qy", want.qy, got.qy);
               if (got.sat !== want.sat) note_mismatch("saturated", 16'(want.sat), 16'(got.sat));
            end
         end
         if (req_tvalid && req_tready) begin
            note = presented_notes.pop_front();
            if (note.fixed) begin
               expected_xforms.push_back(note.want);
            end else begin
               expected_xforms.push_back(transform_point(req_tdata[15:0], req_tdata[31:16]));
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      vector_row_type row;
      xform_cfg_type  cfg;
      point_note_type note;
      int             count;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed vectors
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         cfg = '{row.mode, row.angle, row.ox, row.oy, row.sx, row.sy};
         if (cfg != xf || row.poke) begin
            apply_xform(cfg, 1'b0, row.poke);
         end
         note = '{row.fixed, '{row.qx, row.qy, row.sat}};
         send_point(row.px, row.py, note);
      end

      // random phases, each under a fresh setting; the last runs at full rate
      for (int p = 0; p < NUM_PHASES; p++) begin
         cfg = '{pick_mode(), pick_angle(), pick_word(), pick_word(), pick_word(), pick_word()};
         apply_xform(cfg, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
         if (p == NUM_PHASES - 1) begin
            full_rate     = 1'b1;
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
            count         = TAIL_POINTS;
         end else begin
            req_gap_pct   = 15 * $urandom_range(0, 2);
            rsp_stall_pct = 15 * $urandom_range(0, 2);
            count         = PHASE_POINTS;
         end
         for (int k = 0; k < count; k++) begin
            note = '0;
            send_point(pick_word(), pick_word(), note);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
